// File: hw/rtl/qrt_pkg.sv
// ----------------------------------------------------------------------------
// qrt_pkg
// Shared types, widths and codes of the quorum reply tracker.
// ----------------------------------------------------------------------------
package qrt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int RESULT_CAP  = 16;
   localparam int CNT_W       = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1;

   localparam int OP_W      = 2;
   localparam int ID_W      = 16;
   localparam int KIND_W    = 2;
   localparam int TIME_W    = 16;
   localparam int TMO_W     = 10;
   localparam int REP_W     = 3;
   localparam int TALLY_W   = 3;
   localparam int OUTC_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 10;

   localparam logic [TALLY_W-1:0] TALLY_MAX = 3'd7;

   localparam logic [TMO_W-1:0] TIMEOUT_RST = 10'd10;
   localparam logic [REP_W-1:0] REPLICA_RST = 3'd3;
   localparam logic [REP_W-1:0] QUORUM_RST  = 3'd2;

   typedef enum logic [OP_W-1:0] {
      OP_OPEN   = 2'd0,
      OP_REPLY  = 2'd1,
      OP_TICK   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [OUTC_W-1:0] {
      OUTC_SUCCESS = 2'd0,
      OUTC_FAILURE = 2'd1,
      OUTC_TIMEOUT = 2'd2,
      OUTC_REJECT  = 2'd3
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT = 2'd0,
      CSR_REPLICA = 2'd1,
      CSR_QUORUM  = 2'd2,
      CSR_SPARE   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_OPEN,
      CMD_REPLY,
      CMD_MARK,
      CMD_EMIT
   } cmd_code_type;

   // broadcast to every cell
   typedef struct packed {
      cmd_code_type       code;
      logic [ID_W-1:0]    id;
      logic [KIND_W-1:0]  kind;
      logic               ok;
      logic               dup;
      logic [TIME_W-1:0]  now;
      logic [TMO_W-1:0]   timeout;
      logic [REP_W-1:0]   quorum;
      logic [REP_W:0]     limit;    // replica_count - quorum_size, two's complement
   } cmd_type;

   // handed from cell i to cell i+1
   typedef struct packed {
      logic               free_seen;
      logic               match_seen;
      logic               flag_seen;
      logic               flag_multi;
      logic               res_hit;
      logic [ID_W-1:0]    res_id;
      logic [KIND_W-1:0]  res_kind;
      outcome_type        res_outcome;
   } chain_type;

endpackage

// File: hw/rtl/qrt_cell.sv
// ----------------------------------------------------------------------------
// qrt_cell
// One table entry: id match, reply tally, timeout check and a link in the
// priority chain that picks the lowest free or lowest expired entry.
// ----------------------------------------------------------------------------
module qrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  qrt_pkg::cmd_type   cmd,
   input  qrt_pkg::chain_type chain_in,
   output qrt_pkg::chain_type chain_out
);
   import qrt_pkg::*;

   logic               valid_ff, valid_in;
   logic               flag_ff, flag_in;
   logic [ID_W-1:0]    id_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [TIME_W-1:0]  stamp_ff;
   logic [TALLY_W-1:0] rt_ff, rt_in;
   logic [TALLY_W-1:0] st_ff, st_in;

   logic               match, claim, picked;
   logic [TALLY_W-1:0] rt_new, st_new, fails;
   logic               succ, fail, reply_done, emit_now, expired;
   logic [TIME_W-1:0]  age;

   always_comb begin
      match   = valid_ff && (id_ff == cmd.id);
      claim   = (cmd.code == CMD_OPEN) && !valid_ff && !chain_in.free_seen && !cmd.dup;
      picked  = flag_ff && !chain_in.flag_seen;

      rt_new  = (rt_ff == TALLY_MAX) ? rt_ff : rt_ff + 1'b1;
      st_new  = (cmd.ok && (st_ff != TALLY_MAX)) ? st_ff + 1'b1 : st_ff;
      fails   = rt_new - st_new;
      succ    = (st_new >= cmd.quorum);
      fail    = $signed({1'b0, fails}) > $signed(cmd.limit);

      reply_done = (cmd.code == CMD_REPLY) && match && (succ || fail);
      emit_now   = (cmd.code == CMD_EMIT) && picked;

      age     = cmd.now - stamp_ff;
      expired = valid_ff && (age > {{(TIME_W-TMO_W){1'b0}}, cmd.timeout});

      chain_out.free_seen  = chain_in.free_seen | !valid_ff;
      chain_out.match_seen = chain_in.match_seen | match;
      chain_out.flag_seen  = chain_in.flag_seen | flag_ff;
      chain_out.flag_multi = chain_in.flag_multi | (chain_in.flag_seen & flag_ff);

      if (reply_done) begin
         chain_out.res_hit     = 1'b1;
         chain_out.res_id      = id_ff;
         chain_out.res_kind    = kind_ff;
         chain_out.res_outcome = succ ? OUTC_SUCCESS : OUTC_FAILURE;
      end else if (emit_now) begin
         chain_out.res_hit     = 1'b1;
         chain_out.res_id      = id_ff;
         chain_out.res_kind    = kind_ff;
         chain_out.res_outcome = OUTC_TIMEOUT;
      end else begin
         chain_out.res_hit     = chain_in.res_hit;
         chain_out.res_id      = chain_in.res_id;
         chain_out.res_kind    = chain_in.res_kind;
         chain_out.res_outcome = chain_in.res_outcome;
      end

      valid_in = valid_ff;
      flag_in  = flag_ff;
      rt_in    = rt_ff;
      st_in    = st_ff;
      case (cmd.code)
         CMD_OPEN: begin
            if (claim) begin
               valid_in = 1'b1;
               rt_in    = '0;
               st_in    = '0;
            end
         end
         CMD_REPLY: begin
            if (reply_done) begin
               valid_in = 1'b0;
            end else if (match) begin
               rt_in = rt_new;
               st_in = st_new;
            end
         end
         CMD_MARK: flag_in = expired;
         CMD_EMIT: begin
            if (picked) begin
               valid_in = 1'b0;
               flag_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      rt_ff <= rt_in;
      st_ff <= st_in;
      if (claim) begin
         id_ff    <= cmd.id;
         kind_ff  <= cmd.kind;
         stamp_ff <= cmd.now;
      end
   end

endmodule

// File: hw/rtl/quorum_reply_tracker_top.sv
// ----------------------------------------------------------------------------
// quorum_reply_tracker_top
// Pending-operation table with replica reply tallies and tick timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per accept (op open / reply / tick). req_stall is high
//            while an item is in progress.
//   rsp_*  : completions, rejections and timeouts; rsp_last marks the final
//            result of an item. One output register sits between the table
//            and the receiver.
//   csr_*  : write-only; index 0 timeout_ticks, 1 replica_count, 2 quorum_size.
// Sequence: an open or reply is captured, then makes one table pass
//   through the cell chain. A tick advances time, marks expired entries,
//   then emits their timeouts, or returns to idle when nothing expires;
//   the emit step is driven by the priority chain that selects one expired
//   cell per cycle while rsp_* is free. Unused op codes leave req_stall low.
// Results: a completion or rejection goes from the capture registers
//   through the table pass into the output register; a tick's timeouts
//   follow its mark step, one per cycle while rsp_* is free.
// Stall: while rsp_stall holds a result, the block holds a pending open,
//   reply or emit step and keeps req_stall high; the mark step does not wait.
// Reset: entry valid bits, time counter and control registers return to
//   their defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module quorum_reply_tracker_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [qrt_pkg::OP_W-1:0]       req_op,
   input  logic [qrt_pkg::ID_W-1:0]       req_trans_id,
   input  logic [qrt_pkg::KIND_W-1:0]     req_op_kind,
   input  logic                           req_reply_ok,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [qrt_pkg::ID_W-1:0]       rsp_done_id,
   output logic [qrt_pkg::KIND_W-1:0]     rsp_done_kind,
   output logic [qrt_pkg::OUTC_W-1:0]     rsp_outcome,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [qrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qrt_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import qrt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MARK,
      ST_EMIT
   } state_type;

   state_type           state_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [TMO_W-1:0]    timeout_ff;
   logic [REP_W-1:0]    replica_ff;
   logic [REP_W-1:0]    quorum_ff;
   logic [CNT_W-1:0]    cnt_ff;

   op_type              op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic                ok_ff;

   logic                rsp_valid_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   outcome_type         rsp_outcome_ff;
   logic                rsp_last_ff;

   cmd_type             cmd;
   chain_type           chain [0:TABLE_DEPTH];
   chain_type           chain_end;

   logic                accept, out_free;
   logic                load;
   logic [ID_W-1:0]     load_id;
   logic [KIND_W-1:0]   load_kind;
   outcome_type         load_outcome;
   logic                load_last;

   assign chain[0]  = '0;
   assign chain_end = chain[TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      qrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.id      = id_ff;
      cmd.kind    = kind_ff;
      cmd.ok      = ok_ff;
      cmd.dup     = chain_end.match_seen;
      cmd.now     = time_ff;
      cmd.timeout = timeout_ff;
      cmd.quorum  = quorum_ff;
      cmd.limit   = {1'b0, replica_ff} - {1'b0, quorum_ff};
      cmd.code    = CMD_NONE;
      case (state_ff)
         ST_EXEC: if (out_free) cmd.code = (op_ff == OP_OPEN) ? CMD_OPEN : CMD_REPLY;
         ST_MARK: cmd.code = CMD_MARK;
         ST_EMIT: if (out_free && chain_end.flag_seen) cmd.code = CMD_EMIT;
         default: ;
      endcase
   end

   always_comb begin
      load         = 1'b0;
      load_id      = chain_end.res_id;
      load_kind    = chain_end.res_kind;
      load_outcome = chain_end.res_outcome;
      load_last    = 1'b1;
      case (cmd.code)
         CMD_OPEN: begin
            if (!chain_end.match_seen && !chain_end.free_seen) begin
               load         = 1'b1;
               load_id      = id_ff;
               load_kind    = kind_ff;
               load_outcome = OUTC_REJECT;
            end
         end
         CMD_REPLY: load = chain_end.res_hit;
         CMD_EMIT: begin
            load      = 1'b1;
            load_last = !chain_end.flag_multi || (cnt_ff == CNT_W'(RESULT_CAP - 1));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         timeout_ff   <= TIMEOUT_RST;
         replica_ff   <= REPLICA_RST;
         quorum_ff    <= QUORUM_RST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TIMEOUT: timeout_ff <= csr_wdata[TMO_W-1:0];
               CSR_REPLICA: replica_ff <= csr_wdata[REP_W-1:0];
               CSR_QUORUM:  quorum_ff  <= csr_wdata[REP_W-1:0];
               default: ;
            endcase
         end

         if (out_free) begin
            rsp_valid_ff <= load;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (op_type'(req_op))
                     OP_OPEN, OP_REPLY: state_ff <= ST_EXEC;
                     OP_TICK: begin
                        time_ff  <= time_ff + 1'b1;
                        state_ff <= ST_MARK;
                     end
                     default: ;
                  endcase
               end
            end
            ST_EXEC: if (out_free) state_ff <= ST_IDLE;
            ST_MARK: begin
               cnt_ff   <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!chain_end.flag_seen) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (load_last) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end

      if (accept) begin
         op_ff   <= op_type'(req_op);
         id_ff   <= req_trans_id;
         kind_ff <= req_op_kind;
         ok_ff   <= req_reply_ok;
      end
      if (out_free && load) begin
         rsp_id_ff      <= load_id;
         rsp_kind_ff    <= load_kind;
         rsp_outcome_ff <= load_outcome;
         rsp_last_ff    <= load_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_done_id   = rsp_id_ff;
   assign rsp_done_kind = rsp_kind_ff;
   assign rsp_outcome   = rsp_outcome_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: hw/rtl/qrt_checker.sv
// ----------------------------------------------------------------------------
// qrt_checker
// Port-level checks of the quorum reply tracker, bound to the top level.
// ----------------------------------------------------------------------------
module qrt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [qrt_pkg::OP_W-1:0]       req_op,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [qrt_pkg::ID_W-1:0]       rsp_done_id,
   input logic [qrt_pkg::OUTC_W-1:0]     rsp_outcome,
   input logic                           rsp_last
);
   import qrt_pkg::*;

   // a held result keeps its id, outcome and last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_done_id)
                                    && $stable(rsp_outcome) && $stable(rsp_last)))
      else $error("rsp item changed while stalled");

   // a real op keeps the block busy in the cycle after it is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_op != OP_UNUSED)) |=> req_stall)
      else $error("new item accepted during a table pass");

   // completions from replies and rejections are always single results
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome != OUTC_TIMEOUT)) |-> rsp_last)
      else $error("non-timeout result without last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind quorum_reply_tracker_top qrt_checker u_qrt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_done_id (rsp_done_id),
   .rsp_outcome (rsp_outcome),
   .rsp_last    (rsp_last)
);

// File: bench/quorum_reply_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// quorum_reply_tracker_top_tb
// Self-checking bench for the quorum reply tracker: a tally table model
// predicts every completion, rejection and timeout, and each result item is
// checked field by field in order, under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module quorum_reply_tracker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qrt_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int POOL_SIZE     = 20;
   localparam int PHASE_ITEMS   = 110;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [KIND_W-1:0] kind;
      outcome_type       outcome;
      logic              last;
   } completion_type;

   // Tally table with its own copy of time and registers; completions wait
   // in order of arrival.
   class quorum_scoreboard;
      bit                 live    [TABLE_DEPTH];
      logic [ID_W-1:0]    tag     [TABLE_DEPTH];
      logic [KIND_W-1:0]  kind_of [TABLE_DEPTH];
      logic [TIME_W-1:0]  stamp   [TABLE_DEPTH];
      logic [TALLY_W-1:0] replies [TABLE_DEPTH];
      logic [TALLY_W-1:0] wins    [TABLE_DEPTH];
      logic [TIME_W-1:0]  now_ticks;
      logic [TMO_W-1:0]   timeout_ticks;
      logic [REP_W-1:0]   replicas;
      logic [REP_W-1:0]   quorum;
      completion_type     pending_done [$];
      int                 errors;

      function new();
         foreach (live[i]) live[i] = 1'b0;
         now_ticks     = '0;
         timeout_ticks = TIMEOUT_RST;
         replicas      = REPLICA_RST;
         quorum        = QUORUM_RST;
         errors        = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_TIMEOUT: timeout_ticks = data[TMO_W-1:0];
            CSR_REPLICA: replicas      = data[REP_W-1:0];
            CSR_QUORUM:  quorum        = data[REP_W-1:0];
            default: ;
         endcase
      endfunction

      function int find_slot(logic [ID_W-1:0] id);
         int hit;
         hit = -1;
         for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (live[i] && tag[i] == id) hit = i;
         return hit;
      endfunction

      function void push_done(logic [ID_W-1:0] id, logic [KIND_W-1:0] kind,
                              outcome_type outc, logic last);
         completion_type c;
         c.id      = id;
         c.kind    = kind;
         c.outcome = outc;
         c.last    = last;
         pending_done.insert(pending_done.size(), c);
      endfunction

      function void apply_item(op_type op, logic [ID_W-1:0] id,
                               logic [KIND_W-1:0] kind, logic ok);
         int                slot;
         int                fails;
         int                limit;
         int                hits;
         logic [TIME_W-1:0] age;
         slot = find_slot(id);
         hits = 0;
         case (op)
            OP_OPEN: if (slot < 0) begin
               for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                  if (!live[i]) slot = i;
               if (slot < 0) begin
                  push_done(id, kind, OUTC_REJECT, 1'b1);
               end else begin
                  live[slot]    = 1'b1;
                  tag[slot]     = id;
                  kind_of[slot] = kind;
                  stamp[slot]   = now_ticks;
                  replies[slot] = '0;
                  wins[slot]    = '0;
               end
            end
            OP_REPLY: if (slot >= 0) begin
               if (replies[slot] != TALLY_MAX) replies[slot]++;
               if (ok && wins[slot] != TALLY_MAX) wins[slot]++;
               fails = int'(replies[slot]) - int'(wins[slot]);
               // negative when quorum exceeds replicas: any reply short of quorum fails
               limit = int'(replicas) - int'(quorum);
               if (wins[slot] >= quorum) begin
                  push_done(tag[slot], kind_of[slot], OUTC_SUCCESS, 1'b1);
                  live[slot] = 1'b0;
               end else if (fails > limit) begin
                  push_done(tag[slot], kind_of[slot], OUTC_FAILURE, 1'b1);
                  live[slot] = 1'b0;
               end
            end
            OP_TICK: begin
               now_ticks++;
               for (int i = 0; i < TABLE_DEPTH && hits < RESULT_CAP; i++) begin
                  age = now_ticks - stamp[i];
                  if (live[i] && age > timeout_ticks) begin
                     push_done(tag[i], kind_of[i], OUTC_TIMEOUT, 1'b0);
                     live[i] = 1'b0;
                     hits++;
                  end
               end
               if (hits > 0) pending_done[pending_done.size() - 1].last = 1'b1;
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [ID_W-1:0] want,
                                  logic [ID_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_completion(logic [ID_W-1:0] id, logic [KIND_W-1:0] kind,
                                     logic [OUTC_W-1:0] outc, logic last);
         completion_type want;
         if (pending_done.size() == 0) begin
            errors++;
            $display("%0t: unexpected item id %h kind %0d outcome %0d last %0b",
                     $time, id, kind, outc, last);
         end else begin
            want = pending_done.pop_front();
            compare_field("done_id", want.id, id);
            compare_field("done_kind", ID_W'(want.kind), ID_W'(kind));
            compare_field("outcome", ID_W'(want.outcome), ID_W'(outc));
            compare_field("last", ID_W'(want.last), ID_W'(last));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op       = '0;
   logic [ID_W-1:0]      req_trans_id = '0;
   logic [KIND_W-1:0]    req_op_kind  = '0;
   logic                 req_reply_ok = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   logic [ID_W-1:0]      rsp_done_id;
   logic [KIND_W-1:0]    rsp_done_kind;
   logic [OUTC_W-1:0]    rsp_outcome;
   logic                 rsp_last;
   logic                 csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CSR_DAT_W-1:0] csr_wdata    = '0;

   bit                   calm = 1'b0;
   quorum_scoreboard     sb;

   quorum_reply_tracker_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_trans_id  (req_trans_id),
      .req_op_kind   (req_op_kind),
      .req_reply_ok  (req_reply_ok),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_done_id   (rsp_done_id),
      .rsp_done_kind (rsp_done_kind),
      .rsp_outcome   (rsp_outcome),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAIL quorum_reply_tracker_top");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_completion(rsp_done_id, rsp_done_kind, rsp_outcome, rsp_last);
         if (req_valid && !req_stall)
            sb.apply_item(op_type'(req_op), req_trans_id, req_op_kind, req_reply_ok);
      end
   end

   // valid stays high across back-to-back items
   task automatic send_item(op_type op, logic [ID_W-1:0] id,
                            logic [KIND_W-1:0] kind, logic ok);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_trans_id <= id;
      req_op_kind  <= kind;
      req_reply_ok <= ok;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      // accepted opens, unfinished replies and empty ticks give no result but still occupy the block
      do @(negedge clock);
      while (req_stall || rsp_valid || sb.pending_done.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(logic [TMO_W-1:0] tmo, logic [REP_W-1:0] rep,
                               logic [REP_W-1:0] quo);
      csr_index_type        idx [3];
      logic [CSR_DAT_W-1:0] val [3];
      idx[0] = CSR_TIMEOUT;
      idx[1] = CSR_REPLICA;
      idx[2] = CSR_QUORUM;
      val[0] = CSR_DAT_W'(tmo);
      val[1] = CSR_DAT_W'(rep);
      val[2] = CSR_DAT_W'(quo);
      foreach (idx[i]) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         sb.set_reg(idx[i], val[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin : result_sink
      int hold;
      @(negedge reset);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [ID_W-1:0] pool [POOL_SIZE];
      int              roll;
      int              pick;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: open, duplicate, success, unknown id, failure
      send_item(OP_OPEN,   16'h0000, 2'd0, 1'b0);
      send_item(OP_OPEN,   16'hFFFF, 2'd3, 1'b1);
      send_item(OP_OPEN,   16'h0000, 2'd1, 1'b0);
      send_item(OP_REPLY,  16'h0000, 2'd3, 1'b1);
      send_item(OP_REPLY,  16'h0000, 2'd0, 1'b1);
      send_item(OP_REPLY,  16'h0000, 2'd0, 1'b1);
      send_item(OP_REPLY,  16'hFFFF, 2'd0, 1'b0);
      send_item(OP_REPLY,  16'hFFFF, 2'd0, 1'b0);
      send_item(OP_UNUSED, 16'hFFFF, 2'd3, 1'b1);

      // zero timeout, quorum above replicas: fill, reject, fail, mass expiry
      drain();
      program_regs(10'd0, 3'd1, 3'd7);
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_item(OP_OPEN, 16'(i * 16'h1111), 2'(i), 1'b0);
      send_item(OP_OPEN,  16'hBEEF, 2'd2, 1'b0);
      send_item(OP_REPLY, 16'h1111, 2'd0, 1'b1);
      send_item(OP_TICK,  16'hA5A5, 2'd3, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: program_regs(10'd3, 3'd3, 3'd2);
            1: program_regs(10'd1023, 3'd7, 3'd7);
            2: program_regs(10'd0, 3'd1, 3'd1);
            default: program_regs(10'($urandom_range(0, 15)),
                                  3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)));
         endcase
         calm = (phase == 0);
         foreach (pool[i]) pool[i] = 16'($urandom);
         repeat (PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, POOL_SIZE - 1);
            if (roll < 30)
               send_item(OP_OPEN, pool[pick], 2'($urandom), 1'($urandom));
            else if (roll < 75)
               send_item(OP_REPLY, pool[pick], 2'($urandom), 1'($urandom));
            else if (roll < 88)
               send_item(OP_TICK, 16'($urandom), 2'($urandom), 1'($urandom));
            else if (roll < 94)
               send_item(OP_UNUSED, 16'($urandom), 2'($urandom), 1'($urandom));
            else
               send_item(roll[0] ? OP_OPEN : OP_REPLY, 16'($urandom),
                         2'($urandom), 1'($urandom));
         end
      end

      calm = 1'b0;
      drain();
      if (sb.errors == 0)
         $display("PASS quorum_reply_tracker_top");
      else
         $display("FAIL quorum_reply_tracker_top");
      $finish;
   end

endmodule
